### rtl/core/crs_pkg.sv
// Package of types, constants and helper functions for the compressor run sequencer.
package crs_pkg;

  localparam int MS_W   = 20;
  localparam int DT_W   = 16;
  localparam int PR_W   = 12;
  localparam int MODE_W = 3;
  localparam int CNT_W  = 4;
  localparam int RB_W   = 6;
  localparam int FUNC_W = 2;
  localparam int CIDX_W = 3;

  localparam logic [MS_W-1:0]  PUMP_DELAY_MS  = MS_W'(10000);
  localparam logic [MS_W-1:0]  START_PULSE_MS = MS_W'(2000);
  localparam logic [MS_W-1:0]  STOP_PULSE_MS  = MS_W'(2000);
  localparam logic [MS_W-1:0]  BLEED_RUN_MS   = MS_W'(5000);
  localparam logic [MS_W-1:0]  BLEED_STOP_MS  = MS_W'(2000);
  localparam logic [MS_W-1:0]  FAULT_GRACE_MS = MS_W'(4000);
  localparam logic [CNT_W-1:0] RETRY_LIMIT    = CNT_W'(2);
  localparam logic [CNT_W-1:0] RETRY_SAT      = CNT_W'(15);

  // Relay bit positions.
  localparam int RB_START = 0;
  localparam int RB_STOP  = 1;
  localparam int RB_BLEED = 2;
  localparam int RB_MOTOR = 3;
  localparam int RB_PUMP  = 4;
  localparam int RB_CHILL = 5;

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd3;

  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SHUTDOWN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHILL     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHILL_END = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RUN       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OVERPRESS = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PEAK      = 3'd6;

  localparam logic [CIDX_W-1:0] CFG_FILL_WAIT  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MOTOR_CHK  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_RETRY_WAIT = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HP_MAX     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_HP_READY   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_LP_MAX     = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_LP_READY   = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_LP_MIN     = 3'd7;

  typedef struct packed {
    logic [MS_W-1:0] fill_wait_ms;
    logic [MS_W-1:0] motor_check_ms;
    logic [MS_W-1:0] retry_wait_ms;
    logic [PR_W-1:0] high_pressure_max;
    logic [PR_W-1:0] high_pressure_ready;
    logic [PR_W-1:0] low_pressure_max;
    logic [PR_W-1:0] low_pressure_ready;
    logic [PR_W-1:0] low_pressure_min;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DT_W-1:0]   elapsed_ms;
    logic [PR_W-1:0]   low_pressure;
    logic [PR_W-1:0]   high_pressure;
    logic              compressor_on;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              run_flag;
    logic [RB_W-1:0]   relays;
    logic [PR_W-1:0]   saved_peak;
    logic [CNT_W-1:0]  retry_count;
    logic [MS_W-1:0]   fill_timer;
    logic [MS_W-1:0]   pump_delay_timer;
    logic [MS_W-1:0]   motor_timer;
    logic [MS_W-1:0]   start_pulse_timer;
    logic [MS_W-1:0]   stop_pulse_timer;
    logic [MS_W-1:0]   retry_timer;
    logic [MS_W-1:0]   bleed_timer;
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              run_flag;
    logic [RB_W-1:0]   relays;
  } result_t;

  typedef struct packed {
    logic [MS_W-1:0] value;
    logic            fired;
  } countdown_t;

  // Saturating countdown; fired is set only when a running timer reaches zero.
  function automatic countdown_t count_down(input logic [MS_W-1:0] t,
                                            input logic [DT_W-1:0] d);
    countdown_t      r;
    logic [MS_W-1:0] dz;
    dz      = MS_W'(d);
    r.value = t;
    r.fired = 1'b0;
    if (t != '0) begin
      r.value = (t > dz) ? (t - dz) : '0;
      r.fired = (r.value == '0);
    end
    return r;
  endfunction

  // Release the motor side: stop and bleed relays pulse, run timers cleared.
  function automatic state_t stop_pattern(input state_t s);
    state_t r;
    r                  = s;
    r.relays           = '0;
    r.relays[RB_STOP]  = 1'b1;
    r.relays[RB_BLEED] = 1'b1;
    r.retry_count      = '0;
    r.fill_timer       = '0;
    r.pump_delay_timer = '0;
    r.stop_pulse_timer = STOP_PULSE_MS;
    r.bleed_timer      = BLEED_STOP_MS;
    return r;
  endfunction

endpackage

### rtl/core/crs_item_if.sv
// Interface of the input item channel.
interface crs_item_if;
  logic                     valid;
  logic                     ready;
  logic [crs_pkg::FUNC_W-1:0] func;
  logic [crs_pkg::DT_W-1:0]   elapsed_ms;
  logic [crs_pkg::PR_W-1:0]   low_pressure;
  logic [crs_pkg::PR_W-1:0]   high_pressure;
  logic                     compressor_on;

  modport source (output valid, func, elapsed_ms, low_pressure, high_pressure, compressor_on,
                  input ready);
  modport sink (input valid, func, elapsed_ms, low_pressure, high_pressure, compressor_on,
                output ready);
endinterface

### rtl/core/crs_result_if.sv
// Interface of the result channel.
interface crs_result_if;
  logic                       valid;
  logic                       ready;
  logic [crs_pkg::MODE_W-1:0] mode_code;
  logic                       run_enabled;
  logic                       start_coil;
  logic                       stop_coil;
  logic                       bleed_valve;
  logic                       motor_on;
  logic                       pump_on;
  logic                       chiller_on;

  modport source (output valid, mode_code, run_enabled, start_coil, stop_coil, bleed_valve,
                  motor_on, pump_on, chiller_on, input ready);
  modport sink (input valid, mode_code, run_enabled, start_coil, stop_coil, bleed_valve,
                motor_on, pump_on, chiller_on, output ready);
endinterface

### rtl/core/crs_cfg_if.sv
// Interface of the configuration write channel.
interface crs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [crs_pkg::CIDX_W-1:0] index;
  logic [crs_pkg::MS_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/crs_cfg_regs.sv
// Configuration register file of the compressor run sequencer.
module crs_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  crs_cfg_if.sink       cfg,
  output crs_pkg::cfg_t regs
);
  import crs_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fill_wait_ms        <= MS_W'(120000);
      regs.motor_check_ms      <= MS_W'(30000);
      regs.retry_wait_ms       <= MS_W'(30000);
      regs.high_pressure_max   <= PR_W'(400);
      regs.high_pressure_ready <= PR_W'(350);
      regs.low_pressure_max    <= PR_W'(94);
      regs.low_pressure_ready  <= PR_W'(86);
      regs.low_pressure_min    <= PR_W'(60);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FILL_WAIT:  regs.fill_wait_ms        <= cfg.data;
        CFG_MOTOR_CHK:  regs.motor_check_ms      <= cfg.data;
        CFG_RETRY_WAIT: regs.retry_wait_ms       <= cfg.data;
        CFG_HP_MAX:     regs.high_pressure_max   <= cfg.data[PR_W-1:0];
        CFG_HP_READY:   regs.high_pressure_ready <= cfg.data[PR_W-1:0];
        CFG_LP_MAX:     regs.low_pressure_max    <= cfg.data[PR_W-1:0];
        CFG_LP_READY:   regs.low_pressure_ready  <= cfg.data[PR_W-1:0];
        CFG_LP_MIN:     regs.low_pressure_min    <= cfg.data[PR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/crs_step.sv
// Next-state logic: applies one item to the sequencer state.
module crs_step (
  input  crs_pkg::state_t st,
  input  crs_pkg::item_t  item,
  input  crs_pkg::cfg_t   regs,
  output crs_pkg::state_t st_next
);
  import crs_pkg::*;

  state_t          s;
  countdown_t      cd;
  logic [PR_W-1:0] lp;
  logic [PR_W-1:0] hp;

  assign lp = item.low_pressure;
  assign hp = item.high_pressure;

  always_comb begin
    s  = st;
    cd = '0;
    case (item.func)
      FUNC_TICK: begin
        // Timers are visited in a fixed order; a start pulse loaded on fill
        // expiry is counted down by the same tick.
        cd = count_down(s.fill_timer, item.elapsed_ms);
        s.fill_timer = cd.value;
        if (cd.fired) begin
          s.relays[RB_START]  = 1'b1;
          s.start_pulse_timer = START_PULSE_MS;
        end
        cd = count_down(s.pump_delay_timer, item.elapsed_ms);
        s.pump_delay_timer = cd.value;
        if (cd.fired) s.relays[RB_PUMP] = 1'b1;
        cd = count_down(s.motor_timer, item.elapsed_ms);
        s.motor_timer = cd.value;
        cd = count_down(s.start_pulse_timer, item.elapsed_ms);
        s.start_pulse_timer = cd.value;
        if (cd.fired) s.relays[RB_START] = 1'b0;
        cd = count_down(s.stop_pulse_timer, item.elapsed_ms);
        s.stop_pulse_timer = cd.value;
        if (cd.fired) s.relays[RB_STOP] = 1'b0;
        cd = count_down(s.retry_timer, item.elapsed_ms);
        s.retry_timer = cd.value;
        cd = count_down(s.bleed_timer, item.elapsed_ms);
        s.bleed_timer = cd.value;
        if (cd.fired) s.relays[RB_BLEED] = 1'b0;
      end
      FUNC_SAMPLE: begin
        if (s.run_flag) begin
          s.mode = MODE_IDLE;
          // Start chilling.
          if ((lp < regs.low_pressure_min || hp < regs.high_pressure_ready) &&
              !s.relays[RB_CHILL]) begin
            s.mode             = MODE_CHILL;
            s.relays[RB_CHILL] = 1'b1;
            s.fill_timer       = regs.fill_wait_ms;
          end
          // Stop chilling.
          if (lp > regs.low_pressure_max && s.relays[RB_CHILL]) begin
            s.mode             = MODE_CHILL_END;
            s.relays[RB_STOP]  = 1'b1;
            s.relays[RB_CHILL] = 1'b0;
            s.stop_pulse_timer = STOP_PULSE_MS;
          end
          // Start the motor.
          if (s.fill_timer == '0 && hp < regs.high_pressure_ready &&
              lp > regs.low_pressure_ready && !s.relays[RB_MOTOR]) begin
            s.mode             = MODE_RUN;
            s.relays[RB_BLEED] = 1'b1;
            s.relays[RB_MOTOR] = 1'b1;
            s.bleed_timer      = BLEED_RUN_MS;
            s.pump_delay_timer = PUMP_DELAY_MS;
            s.motor_timer      = regs.motor_check_ms;
            s.saved_peak       = hp;
          end
          // Overpressure or starved suction stops the motor.
          if ((hp > regs.high_pressure_max || lp < regs.low_pressure_min) &&
              s.relays[RB_MOTOR]) begin
            s.mode             = MODE_OVERPRESS;
            s.relays[RB_BLEED] = 1'b1;
            s.relays[RB_MOTOR] = 1'b0;
            s.relays[RB_PUMP]  = 1'b0;
            s.bleed_timer      = BLEED_RUN_MS;
            s.pump_delay_timer = '0;
          end
          // Peak check: pressure must keep rising, else retry and shut down.
          if (s.motor_timer == '0 && s.retry_timer == '0 && s.relays[RB_MOTOR]) begin
            s.mode = MODE_PEAK;
            if (hp > s.saved_peak) begin
              s.motor_timer = regs.motor_check_ms;
              s.saved_peak  = hp;
              s.retry_count = '0;
            end else begin
              if (s.retry_count < RETRY_SAT) s.retry_count = s.retry_count + 1'b1;
              if (s.retry_count >= RETRY_LIMIT) begin
                s          = stop_pattern(s);
                s.mode     = MODE_SHUTDOWN;
                s.run_flag = 1'b0;
              end else begin
                s.retry_timer = regs.retry_wait_ms;
              end
            end
          end
          // Compressor fault once the pump delay is nearly over.
          if (s.relays[RB_MOTOR] && !item.compressor_on &&
              s.pump_delay_timer <= FAULT_GRACE_MS) begin
            s.run_flag = 1'b0;
            s.mode     = MODE_SHUTDOWN;
          end
        end else if (s.mode == MODE_SHUTDOWN) begin
          s      = stop_pattern(s);
          s.mode = MODE_IDLE;
        end
      end
      FUNC_START: begin
        s.run_flag = 1'b1;
      end
      default: begin
        s.run_flag = 1'b0;
        s.mode     = MODE_SHUTDOWN;
      end
    endcase
    st_next = s;
  end

endmodule

### rtl/core/compressor_run_sequencer_top.sv
// Top level of the compressor run sequencer: item register, state, result register.
// Throughput: one item per cycle while the result side takes results; the state
// update is a single pass of compare and subtract logic between the item register
// and the state and result registers. An item moves on only when the result
// register is free or is being emptied; a stalled result side holds it back.
// Reset (rst, synchronous, active high) empties both stages, clears the sequencer
// state and loads the configuration registers with their default values.
module compressor_run_sequencer_top (
  input logic        clk,
  input logic        rst,
  crs_item_if.sink   item,
  crs_result_if.source result,
  crs_cfg_if.sink    cfg
);
  import crs_pkg::*;

  cfg_t    regs;
  item_t   item_q;
  logic    item_full;
  state_t  st;
  state_t  st_next;
  result_t res_q;
  logic    res_full;
  logic    advance;

  // Config registers: the user writes only while the block is idle; not enforced.
  crs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // The held item moves on whenever the result register is free or is being
  // emptied by a transfer in this same cycle. The input side therefore keeps
  // taking a new item every cycle while results flow out.
  assign advance    = item_full && (!res_full || result.ready);
  assign item.ready = !item_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item.ready) begin
      item_full <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q.func          <= item.func;
      item_q.elapsed_ms    <= item.elapsed_ms;
      item_q.low_pressure  <= item.low_pressure;
      item_q.high_pressure <= item.high_pressure;
      item_q.compressor_on <= item.compressor_on;
    end
  end

  // All of the work for one item: the timer countdowns, the ordered pressure tests
  // or a start or stop command, evaluated on the current state.
  crs_step u_step (
    .st      (st),
    .item    (item_q),
    .regs    (regs),
    .st_next (st_next)
  );

  // Sequencer state is committed in the same cycle as the result is captured,
  // so the following item sees it at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (result.ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q.mode     <= st_next.mode;
      res_q.run_flag <= st_next.run_flag;
      res_q.relays   <= st_next.relays;
    end
  end

  assign result.valid       = res_full;
  assign result.mode_code   = res_q.mode;
  assign result.run_enabled = res_q.run_flag;
  assign result.start_coil  = res_q.relays[RB_START];
  assign result.stop_coil   = res_q.relays[RB_STOP];
  assign result.bleed_valve = res_q.relays[RB_BLEED];
  assign result.motor_on    = res_q.relays[RB_MOTOR];
  assign result.pump_on     = res_q.relays[RB_PUMP];
  assign result.chiller_on  = res_q.relays[RB_CHILL];

`ifndef SYNTHESIS
  // A processed item always leaves a result behind it.
  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_full)
    else $error("result register empty after an item was processed");

  // A held item that cannot move on stays put.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_full && !advance) |=> (item_full && $stable(item_q)))
    else $error("held item lost or changed while stalled");

  // Reaching the retry limit clears the count, so it stays below the limit.
  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    advance |=> (st.retry_count < RETRY_LIMIT))
    else $error("retry count reached the limit");

  // The state only changes when an item is processed.
  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("sequencer state changed with no item");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the compressor run sequencer, with its own model of the sequencer.
`timescale 1ns / 100ps

module tb_top;
  import crs_pkg::*;

  // A correct run never goes this long without a transfer on some channel. The longest quiet
  // stretch is the deliberate receiver hold plus one sender gap and one receiver stall.
  localparam int WATCHDOG_LIMIT = 2000;
  // The receiver holds off once for this many cycles, after this many results.
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_RESULT = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Channels, driven from local variables so that every input is known from time zero.
  crs_item_if   item_ch ();
  crs_result_if result_ch ();
  crs_cfg_if    cfg_ch ();

  logic              in_valid  = 1'b0;
  item_t             in_data   = '0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]   cfg_data  = '0;

  assign item_ch.valid         = in_valid;
  assign item_ch.func          = in_data.func;
  assign item_ch.elapsed_ms    = in_data.elapsed_ms;
  assign item_ch.low_pressure  = in_data.low_pressure;
  assign item_ch.high_pressure = in_data.high_pressure;
  assign item_ch.compressor_on = in_data.compressor_on;
  assign result_ch.ready       = out_ready;
  assign cfg_ch.valid          = cfg_valid;
  assign cfg_ch.index          = cfg_index;
  assign cfg_ch.data           = cfg_data;

  compressor_run_sequencer_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------------------
  // Model of the sequencer: limits as last written, and the state as after the last item.
  // ---------------------------------------------------------------------------------------
  cfg_t limits;

  logic [MODE_W-1:0] seq_mode    = MODE_IDLE;
  logic              seq_run     = 1'b0;
  logic [RB_W-1:0]   seq_relays  = '0;
  logic [PR_W-1:0]   seq_peak    = '0;
  logic [CNT_W-1:0]  seq_retries = '0;
  logic [MS_W-1:0]   fill_tmr    = '0;
  logic [MS_W-1:0]   pump_tmr    = '0;
  logic [MS_W-1:0]   motor_tmr   = '0;
  logic [MS_W-1:0]   start_tmr   = '0;
  logic [MS_W-1:0]   stop_tmr    = '0;
  logic [MS_W-1:0]   retry_tmr   = '0;
  logic [MS_W-1:0]   bleed_tmr   = '0;

  // Items waiting to be offered, and results owed by the block, oldest first.
  item_t   pending_items[$];
  result_t expected_results[$];

  int queued_total   = 0;
  int accepted_total = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int send_gap       = 0;
  int send_calm      = 0;
  int recv_gap       = 0;
  int recv_calm      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // One timer step: the new value in the low bits, and the top bit set only when a running
  // timer reaches zero on this tick. A timer already at zero stays put and does not fire.
  function automatic logic [MS_W:0] run_down(input logic [MS_W-1:0] t,
                                             input logic [DT_W-1:0] d);
    logic [MS_W-1:0] dd;
    dd = MS_W'(d);
    if (t == '0) return {1'b0, t};
    if (t > dd) return {1'b0, t - dd};
    return {1'b1, {MS_W{1'b0}}};
  endfunction

  // Motor side released: stop and bleed pulses, everything else off, run timers cleared.
  function automatic void release_motor();
    seq_relays            = '0;
    seq_relays[RB_STOP]   = 1'b1;
    seq_relays[RB_BLEED]  = 1'b1;
    seq_retries           = '0;
    fill_tmr              = '0;
    pump_tmr              = '0;
    stop_tmr              = STOP_PULSE_MS;
    bleed_tmr             = BLEED_STOP_MS;
  endfunction

  // Applies one item to the model and returns the mode and drives that should follow it.
  function automatic result_t step_sequencer(input item_t it);
    result_t         r;
    logic [MS_W:0]   t;
    logic [PR_W-1:0] lp;
    logic [PR_W-1:0] hp;
    lp = it.low_pressure;
    hp = it.high_pressure;
    case (it.func)
      FUNC_TICK: begin
        // Fixed order: an expiring fill timer loads the start pulse, which this same tick
        // then counts down as well.
        t = run_down(fill_tmr, it.elapsed_ms);
        fill_tmr = t[MS_W-1:0];
        if (t[MS_W]) begin
          seq_relays[RB_START] = 1'b1;
          start_tmr = START_PULSE_MS;
        end
        t = run_down(pump_tmr, it.elapsed_ms);
        pump_tmr = t[MS_W-1:0];
        if (t[MS_W]) seq_relays[RB_PUMP] = 1'b1;
        t = run_down(motor_tmr, it.elapsed_ms);
        motor_tmr = t[MS_W-1:0];
        t = run_down(start_tmr, it.elapsed_ms);
        start_tmr = t[MS_W-1:0];
        if (t[MS_W]) seq_relays[RB_START] = 1'b0;
        t = run_down(stop_tmr, it.elapsed_ms);
        stop_tmr = t[MS_W-1:0];
        if (t[MS_W]) seq_relays[RB_STOP] = 1'b0;
        t = run_down(retry_tmr, it.elapsed_ms);
        retry_tmr = t[MS_W-1:0];
        t = run_down(bleed_tmr, it.elapsed_ms);
        bleed_tmr = t[MS_W-1:0];
        if (t[MS_W]) seq_relays[RB_BLEED] = 1'b0;
      end
      FUNC_SAMPLE: begin
        if (seq_run) begin
          // The tests run in a fixed order and each one sees what the earlier ones changed.
          seq_mode = MODE_IDLE;
          if ((lp < limits.low_pressure_min || hp < limits.high_pressure_ready) &&
              !seq_relays[RB_CHILL]) begin
            seq_mode = MODE_CHILL;
            seq_relays[RB_CHILL] = 1'b1;
            fill_tmr = limits.fill_wait_ms;
          end
          if (lp > limits.low_pressure_max && seq_relays[RB_CHILL]) begin
            seq_mode = MODE_CHILL_END;
            seq_relays[RB_STOP]  = 1'b1;
            seq_relays[RB_CHILL] = 1'b0;
            stop_tmr = STOP_PULSE_MS;
          end
          if (fill_tmr == '0 && hp < limits.high_pressure_ready &&
              lp > limits.low_pressure_ready && !seq_relays[RB_MOTOR]) begin
            seq_mode = MODE_RUN;
            seq_relays[RB_BLEED] = 1'b1;
            seq_relays[RB_MOTOR] = 1'b1;
            bleed_tmr = BLEED_RUN_MS;
            pump_tmr  = PUMP_DELAY_MS;
            motor_tmr = limits.motor_check_ms;
            seq_peak  = hp;
          end
          if ((hp > limits.high_pressure_max || lp < limits.low_pressure_min) &&
              seq_relays[RB_MOTOR]) begin
            seq_mode = MODE_OVERPRESS;
            seq_relays[RB_BLEED] = 1'b1;
            seq_relays[RB_MOTOR] = 1'b0;
            seq_relays[RB_PUMP]  = 1'b0;
            bleed_tmr = BLEED_RUN_MS;
            pump_tmr  = '0;
          end
          if (motor_tmr == '0 && retry_tmr == '0 && seq_relays[RB_MOTOR]) begin
            seq_mode = MODE_PEAK;
            if (hp > seq_peak) begin
              motor_tmr   = limits.motor_check_ms;
              seq_peak    = hp;
              seq_retries = '0;
            end else begin
              if (seq_retries < RETRY_SAT) seq_retries = seq_retries + 1'b1;
              if (seq_retries >= RETRY_LIMIT) begin
                seq_mode = MODE_SHUTDOWN;
                release_motor();
                seq_run = 1'b0;
              end else begin
                retry_tmr = limits.retry_wait_ms;
              end
            end
          end
          // A compressor fault only drops the run flag; the relays stay until the next sample.
          if (seq_relays[RB_MOTOR] && !it.compressor_on && pump_tmr <= FAULT_GRACE_MS) begin
            seq_run  = 1'b0;
            seq_mode = MODE_SHUTDOWN;
          end
        end else if (seq_mode == MODE_SHUTDOWN) begin
          release_motor();
          seq_mode = MODE_IDLE;
        end
      end
      FUNC_START: seq_run = 1'b1;
      default: begin
        seq_run  = 1'b0;
        seq_mode = MODE_SHUTDOWN;
      end
    endcase
    r.mode     = seq_mode;
    r.run_flag = seq_run;
    r.relays   = seq_relays;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Item builders. Fields that the item's function ignores carry random values, so that the
  // block is seen to ignore them.
  // ---------------------------------------------------------------------------------------
  function automatic item_t tick_item(input logic [DT_W-1:0] ms);
    item_t it;
    it.func          = FUNC_TICK;
    it.elapsed_ms    = ms;
    it.low_pressure  = PR_W'($urandom);
    it.high_pressure = PR_W'($urandom);
    it.compressor_on = 1'($urandom);
    return it;
  endfunction

  function automatic item_t sample_item(input logic [PR_W-1:0] lp, input logic [PR_W-1:0] hp,
                                        input logic comp);
    item_t it;
    it.func          = FUNC_SAMPLE;
    it.elapsed_ms    = DT_W'($urandom);
    it.low_pressure  = lp;
    it.high_pressure = hp;
    it.compressor_on = comp;
    return it;
  endfunction

  function automatic item_t command_item(input logic [FUNC_W-1:0] f);
    item_t it;
    it               = tick_item(DT_W'($urandom));
    it.func          = f;
    return it;
  endfunction

  // A reading close to one of two limits, so that the comparisons flip often; now and then a
  // reading from anywhere in the range, or one of its ends.
  function automatic logic [PR_W-1:0] near_level(input logic [PR_W-1:0] a,
                                                 input logic [PR_W-1:0] b);
    logic [PR_W-1:0] th;
    th = $urandom_range(0, 1) ? a : b;
    case ($urandom_range(0, 7))
      0: return th;
      1: return th + 1'b1;
      2: return th - 1'b1;
      3: return PR_W'($urandom_range(0, 4095));
      4: return $urandom_range(0, 1) ? '0 : '1;
      default: return th + PR_W'($urandom_range(0, 30)) - PR_W'(15);
    endcase
  endfunction

  // Draws the wait before the next transfer on one side: mostly a uniformly drawn idle,
  // broken by calm stretches in which that side never idles.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic offer(input item_t it);
    pending_items.push_back(it);
    queued_total++;
  endtask

  // Random traffic shaped as a run: a start first, then mostly ticks and samples near the
  // current limits, with the odd start or stop thrown in.
  task automatic queue_random(input int n);
    item_t it;
    int    pick;
    offer(command_item(FUNC_START));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        it = command_item(FUNC_START);
      end else if (pick < 11) begin
        it = command_item(FUNC_STOP);
      end else if (pick < 50) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: it = tick_item(DT_W'($urandom_range(0, 3000)));
          5, 6, 7:       it = tick_item(DT_W'($urandom_range(0, 20000)));
          default:       it = tick_item(DT_W'($urandom_range(0, 65535)));
        endcase
      end else begin
        it = sample_item(near_level($urandom_range(0, 1) ? limits.low_pressure_min
                                                         : limits.low_pressure_ready,
                                    limits.low_pressure_max),
                         near_level(limits.high_pressure_ready, limits.high_pressure_max),
                         1'($urandom_range(0, 9) != 0));
      end
      offer(it);
    end
  endtask

  // Waits until every queued item has been transferred and every result checked, then lets
  // the block settle.
  task automatic settle();
    while (accepted_total != queued_total || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One register write, held until the block takes it; the model follows at that edge.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [MS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FILL_WAIT:  limits.fill_wait_ms        = val;
      CFG_MOTOR_CHK:  limits.motor_check_ms      = val;
      CFG_RETRY_WAIT: limits.retry_wait_ms       = val;
      CFG_HP_MAX:     limits.high_pressure_max   = val[PR_W-1:0];
      CFG_HP_READY:   limits.high_pressure_ready = val[PR_W-1:0];
      CFG_LP_MAX:     limits.low_pressure_max    = val[PR_W-1:0];
      CFG_LP_READY:   limits.low_pressure_ready  = val[PR_W-1:0];
      default:        limits.low_pressure_min    = val[PR_W-1:0];
    endcase
  endtask

  // Writes all eight registers. The pressure limits go out with random upper bits, which the
  // block has to drop.
  task automatic write_limits(input logic [MS_W-1:0] fill, input logic [MS_W-1:0] motor,
                              input logic [MS_W-1:0] retry, input logic [PR_W-1:0] hp_max,
                              input logic [PR_W-1:0] hp_ready, input logic [PR_W-1:0] lp_max,
                              input logic [PR_W-1:0] lp_ready, input logic [PR_W-1:0] lp_min);
    write_reg(CFG_FILL_WAIT, fill);
    write_reg(CFG_MOTOR_CHK, motor);
    write_reg(CFG_RETRY_WAIT, retry);
    write_reg(CFG_HP_MAX, {8'($urandom), hp_max});
    write_reg(CFG_HP_READY, {8'($urandom), hp_ready});
    write_reg(CFG_LP_MAX, {8'($urandom), lp_max});
    write_reg(CFG_LP_READY, {8'($urandom), lp_ready});
    write_reg(CFG_LP_MIN, {8'($urandom), lp_min});
  endtask

  // Short timers and limits kept in a sensible order, so that whole runs fit in a phase.
  task automatic random_limits();
    logic [PR_W-1:0] lp_min;
    logic [PR_W-1:0] lp_ready;
    logic [PR_W-1:0] hp_ready;
    lp_min   = PR_W'($urandom_range(30, 90));
    lp_ready = lp_min + PR_W'($urandom_range(0, 40));
    hp_ready = PR_W'($urandom_range(200, 500));
    write_limits(MS_W'($urandom_range(0, 20000)), MS_W'($urandom_range(0, 20000)),
                 MS_W'($urandom_range(0, 20000)), hp_ready + PR_W'($urandom_range(0, 100)),
                 hp_ready, lp_ready + PR_W'($urandom_range(0, 40)), lp_ready, lp_min);
  endtask

  // ---------------------------------------------------------------------------------------
  // Item driver. At each rising edge it first books a transfer that has just completed: the
  // model takes the item and the expected result joins the queue. Only when the channel is
  // free does it move on, either idling for the drawn number of cycles or offering the next
  // pending item. While an offer is waiting for ready, valid and the payload stay put.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && item_ch.ready) begin
        expected_results.push_back(step_sequencer(in_data));
        accepted_total++;
      end
      if (!in_valid || item_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result monitor. Each result transfer is matched against the oldest expectation. After a
  // transfer the receiver stalls for a drawn number of cycles. Once, well into the random
  // traffic, it holds ready low for a long stretch while the driver keeps offering items, so
  // that the block fills up and has to stall its input.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_ch.valid && out_ready) begin
        got.mode                = result_ch.mode_code;
        got.run_flag            = result_ch.run_enabled;
        got.relays[RB_START]    = result_ch.start_coil;
        got.relays[RB_STOP]     = result_ch.stop_coil;
        got.relays[RB_BLEED]    = result_ch.bleed_valve;
        got.relays[RB_MOTOR]    = result_ch.motor_on;
        got.relays[RB_PUMP]     = result_ch.pump_on;
        got.relays[RB_CHILL]    = result_ch.chiller_on;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: mode %0d run %b relays %b",
                     results_seen, got.mode, got.run_flag, got.relays);
        end else begin
          want = expected_results.pop_front();
          if (got.mode !== want.mode || got.run_flag !== want.run_flag ||
              got.relays !== want.relays) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected mode %0d run %b relays %b, got mode %0d run %b %s%b",
                       results_seen, want.mode, want.run_flag, want.relays,
                       got.mode, got.run_flag, "relays ", got.relays);
          end
        end
        results_seen++;
        recv_gap = draw_wait(recv_calm);
        if (results_seen == HOLD_AT_RESULT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && item_ch.ready) || (result_ch.valid && out_ready) ||
        (cfg_valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus, phase by phase. Registers are only written once the block has gone quiet.
  // ---------------------------------------------------------------------------------------
  initial begin
    limits.fill_wait_ms        = MS_W'(120000);
    limits.motor_check_ms      = MS_W'(30000);
    limits.retry_wait_ms       = MS_W'(30000);
    limits.high_pressure_max   = PR_W'(400);
    limits.high_pressure_ready = PR_W'(350);
    limits.low_pressure_max    = PR_W'(94);
    limits.low_pressure_ready  = PR_W'(86);
    limits.low_pressure_min    = PR_W'(60);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Limits as after reset. A sample while stopped changes nothing, a stop shuts down and
    // the next sample releases the relays; then the pulses run out.
    offer(sample_item('0, '0, 1'b0));
    offer(command_item(FUNC_STOP));
    offer(sample_item('1, '1, 1'b1));
    offer(tick_item('0));
    offer(tick_item('1));
    // Chill, then the long fill wait: the last tick leaves part of the start pulse showing,
    // the one after it ends the pulse.
    offer(command_item(FUNC_START));
    offer(sample_item(PR_W'(50), PR_W'(300), 1'b1));
    offer(tick_item('1));
    offer(tick_item(DT_W'(54000)));
    offer(tick_item(DT_W'(465)));
    offer(tick_item(DT_W'(1535)));
    // Chill ends and the motor starts on the same sample; then a rising peak check, a flat
    // one that arms the retry, and a compressor fault that the following sample clears up.
    offer(sample_item(PR_W'(95), PR_W'(300), 1'b1));
    offer(tick_item(DT_W'(30000)));
    offer(sample_item(PR_W'(90), PR_W'(380), 1'b1));
    offer(tick_item(DT_W'(30000)));
    offer(sample_item(PR_W'(90), PR_W'(370), 1'b1));
    offer(sample_item(PR_W'(90), PR_W'(370), 1'b0));
    offer(sample_item(PR_W'(90), PR_W'(370), 1'b1));
    offer(tick_item('1));
    queue_random(60);
    settle();

    // All timers zero: the peak check comes straight away and the retry limit shuts the
    // motor down on the second flat check; then an overpressure on a fresh run.
    write_limits('0, '0, '0, PR_W'(400), PR_W'(350), PR_W'(94), PR_W'(86), PR_W'(60));
    offer(command_item(FUNC_START));
    offer(sample_item(PR_W'(90), PR_W'(300), 1'b1));
    offer(sample_item(PR_W'(90), PR_W'(300), 1'b1));
    offer(sample_item(PR_W'(90), PR_W'(300), 1'b1));
    offer(command_item(FUNC_START));
    offer(sample_item(PR_W'(90), PR_W'(300), 1'b1));
    offer(sample_item(PR_W'(90), PR_W'(4095), 1'b1));
    queue_random(60);
    settle();

    // Short timers with the usual limits, where whole runs come and go quickly.
    write_limits(MS_W'(1500), MS_W'(4000), MS_W'(3000), PR_W'(400), PR_W'(350), PR_W'(94),
                 PR_W'(86), PR_W'(60));
    queue_random(80);
    settle();

    // Every register at its top value.
    write_limits('1, '1, '1, '1, '1, '1, '1, '1);
    queue_random(40);
    settle();

    random_limits();
    queue_random(90);
    settle();

    random_limits();
    queue_random(50);
    settle();

    // Pressure limits at zero.
    write_limits(MS_W'(700), MS_W'(900), MS_W'(500), '0, '0, '0, '0, '0);
    queue_random(20);
    settle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/crs_pkg.sv
rtl/core/crs_item_if.sv
rtl/core/crs_result_if.sv
rtl/core/crs_cfg_if.sv
rtl/core/crs_cfg_regs.sv
rtl/core/crs_step.sv
rtl/core/compressor_run_sequencer_top.sv
tb/tb_top.sv
